### hw/rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// Source text lexer package
// Lexer modes, token kinds, the token record and character class functions.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int ByteW = 8;
    localparam int KindW = 3;
    localparam int ModeW = 3;

    // Lexer modes; the unused code acts as idle.
    localparam logic [ModeW-1:0] MODE_IDLE    = 3'd0;
    localparam logic [ModeW-1:0] MODE_IDENT   = 3'd1;
    localparam logic [ModeW-1:0] MODE_NUMBER  = 3'd2;
    localparam logic [ModeW-1:0] MODE_STRING  = 3'd3;
    localparam logic [ModeW-1:0] MODE_ESCAPE  = 3'd4;
    localparam logic [ModeW-1:0] MODE_COMMENT = 3'd5;
    localparam logic [ModeW-1:0] MODE_OPPEND  = 3'd6;

    // Token kinds.
    localparam logic [KindW-1:0] KIND_NEWLINE = 3'd0;
    localparam logic [KindW-1:0] KIND_IDENT   = 3'd1;
    localparam logic [KindW-1:0] KIND_NUMBER  = 3'd2;
    localparam logic [KindW-1:0] KIND_STRING  = 3'd3;
    localparam logic [KindW-1:0] KIND_OP      = 3'd4;

    localparam logic [ByteW-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [ByteW-1:0] CH_SPACE     = 8'h20;
    localparam logic [ByteW-1:0] CH_DEL       = 8'h7F;
    localparam logic [ByteW-1:0] CH_QUOTE     = 8'h22;
    localparam logic [ByteW-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [ByteW-1:0] CH_SLASH     = 8'h2F;
    localparam logic [ByteW-1:0] CH_DOT       = 8'h2E;
    localparam logic [ByteW-1:0] CH_EQUAL     = 8'h3D;

    typedef struct packed {
        logic [ByteW-1:0] ch;
        logic [KindW-1:0] kind;
        logic             first;
        logic             last;
    } tok_t;

    // A result entry as it waits in the output buffer.
    typedef struct packed {
        tok_t tok;
        logic run_end;
    } res_t;

    function automatic logic is_letter(input logic [ByteW-1:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_digit(input logic [ByteW-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // Characters that may open a two-character operator.
    function automatic logic is_starter(input logic [ByteW-1:0] c);
        return c inside {8'h3C, 8'h3E, 8'h26, 8'h7C, 8'h2B, 8'h2D, 8'h3D,
                         8'h21, 8'h3A, 8'h2A, 8'h2F, 8'h25, 8'h5E};
    endfunction

    // The first group pairs with itself or an '='; the others only with an '='.
    function automatic logic is_pair(input logic [ByteW-1:0] a,
                                     input logic [ByteW-1:0] c);
        logic r;
        r = 1'b0;
        case (a)
            8'h3C, 8'h3E, 8'h26, 8'h7C, 8'h2B, 8'h2D, 8'h3D:
                r = (c == a) || (c == CH_EQUAL);
            8'h21, 8'h3A, 8'h2A, 8'h2F, 8'h25, 8'h5E:
                r = (c == CH_EQUAL);
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/stl_core.sv
// ----------------------------------------------------------------------------
// Source text lexer core
// Holds the lexer mode and the held byte, and turns one source item into
// up to two token results combinationally.
// ----------------------------------------------------------------------------
module stl_core
    import stl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [ByteW-1:0] in_byte,
    input  logic             is_end,
    output tok_t             res0,
    output tok_t             res1,
    output logic [1:0]       res_cnt
);

    logic [ModeW-1:0] mode_reg, mode_next;
    logic [ByteW-1:0] held_byte_reg, held_byte_next;
    logic             held_first_reg, held_first_next;

    // Outcome of a byte seen at top level with nothing pending.
    logic             fr_emit;
    logic             fr_hold;
    tok_t             fr_tok;
    logic [ModeW-1:0] fr_mode;

    always_comb
    begin
        fr_emit = 1'b0;
        fr_hold = 1'b0;
        fr_tok  = '0;
        fr_mode = MODE_IDLE;
        if (in_byte == CH_NEWLINE)
        begin
            fr_emit = 1'b1;
            fr_tok  = '{CH_NEWLINE, KIND_NEWLINE, 1'b1, 1'b1};
        end
        else if (in_byte <= CH_SPACE || in_byte >= CH_DEL)
        begin
            fr_emit = 1'b0;
        end
        else if (in_byte == CH_QUOTE)
        begin
            fr_emit = 1'b1;
            fr_tok  = '{in_byte, KIND_STRING, 1'b1, 1'b0};
            fr_mode = MODE_STRING;
        end
        else if (is_letter(in_byte))
        begin
            fr_hold = 1'b1;
            fr_mode = MODE_IDENT;
        end
        else if (is_digit(in_byte))
        begin
            fr_hold = 1'b1;
            fr_mode = MODE_NUMBER;
        end
        else if (is_starter(in_byte))
        begin
            fr_hold = 1'b1;
            fr_mode = MODE_OPPEND;
        end
        else
        begin
            fr_emit = 1'b1;
            fr_tok  = '{in_byte, KIND_OP, 1'b1, 1'b1};
        end
    end

    logic goes_on;

    always_comb
    begin
        mode_next       = mode_reg;
        held_byte_next  = held_byte_reg;
        held_first_next = held_first_reg;
        res0            = '0;
        res1            = '0;
        res_cnt         = 2'd0;
        goes_on         = 1'b0;

        if (is_end)
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    res0    = '{held_byte_reg, KIND_IDENT, held_first_reg, 1'b1};
                    res_cnt = 2'd1;
                end
                MODE_NUMBER:
                begin
                    res0    = '{held_byte_reg, KIND_NUMBER, held_first_reg, 1'b1};
                    res_cnt = 2'd1;
                end
                MODE_STRING, MODE_ESCAPE:
                begin
                    res0    = '{CH_QUOTE, KIND_STRING, 1'b0, 1'b1};
                    res_cnt = 2'd1;
                end
                MODE_COMMENT:
                begin
                    res0    = '{CH_NEWLINE, KIND_NEWLINE, 1'b1, 1'b1};
                    res_cnt = 2'd1;
                end
                MODE_OPPEND:
                begin
                    res0    = '{held_byte_reg, KIND_OP, 1'b1, 1'b1};
                    res_cnt = 2'd1;
                end
                default:
                begin
                    res_cnt = 2'd0;
                end
            endcase
            mode_next       = MODE_IDLE;
            held_byte_next  = '0;
            held_first_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT, MODE_NUMBER:
                begin
                    if (mode_reg == MODE_IDENT)
                    begin
                        goes_on = is_letter(in_byte) || is_digit(in_byte);
                    end
                    else
                    begin
                        goes_on = is_digit(in_byte) || (in_byte == CH_DOT);
                    end
                    res0.ch    = held_byte_reg;
                    res0.kind  = (mode_reg == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
                    res0.first = held_first_reg;
                    if (goes_on)
                    begin
                        res0.last       = 1'b0;
                        res_cnt         = 2'd1;
                        held_byte_next  = in_byte;
                        held_first_next = 1'b0;
                    end
                    else
                    begin
                        res0.last       = 1'b1;
                        res1            = fr_tok;
                        res_cnt         = fr_emit ? 2'd2 : 2'd1;
                        mode_next       = fr_mode;
                        held_byte_next  = fr_hold ? in_byte : '0;
                        held_first_next = fr_hold;
                    end
                end
                MODE_STRING:
                begin
                    res0    = '{in_byte, KIND_STRING, 1'b0, in_byte == CH_QUOTE};
                    res_cnt = 2'd1;
                    if (in_byte == CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else if (in_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_ESCAPE:
                begin
                    res0      = '{in_byte, KIND_STRING, 1'b0, 1'b0};
                    res_cnt   = 2'd1;
                    mode_next = MODE_STRING;
                end
                MODE_COMMENT:
                begin
                    if (in_byte == CH_NEWLINE)
                    begin
                        res0      = '{CH_NEWLINE, KIND_NEWLINE, 1'b1, 1'b1};
                        res_cnt   = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_OPPEND:
                begin
                    if (held_byte_reg == CH_SLASH && in_byte == CH_SLASH)
                    begin
                        mode_next       = MODE_COMMENT;
                        held_byte_next  = '0;
                        held_first_next = 1'b0;
                    end
                    else if (is_pair(held_byte_reg, in_byte))
                    begin
                        res0            = '{held_byte_reg, KIND_OP, 1'b1, 1'b0};
                        res1            = '{in_byte, KIND_OP, 1'b0, 1'b1};
                        res_cnt         = 2'd2;
                        mode_next       = MODE_IDLE;
                        held_byte_next  = '0;
                        held_first_next = 1'b0;
                    end
                    else
                    begin
                        res0            = '{held_byte_reg, KIND_OP, 1'b1, 1'b1};
                        res1            = fr_tok;
                        res_cnt         = fr_emit ? 2'd2 : 2'd1;
                        mode_next       = fr_mode;
                        held_byte_next  = fr_hold ? in_byte : '0;
                        held_first_next = fr_hold;
                    end
                end
                default:
                begin
                    res0            = fr_tok;
                    res_cnt         = fr_emit ? 2'd1 : 2'd0;
                    mode_next       = fr_mode;
                    held_byte_next  = fr_hold ? in_byte : '0;
                    held_first_next = fr_hold;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            held_byte_reg  <= '0;
            held_first_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg       <= mode_next;
            held_byte_reg  <= held_byte_next;
            held_first_reg <= held_first_next;
        end
    end

endmodule

### hw/rtl/stl_outbuf.sv
// ----------------------------------------------------------------------------
// Source text lexer output buffer
// Two-entry result register that presents the results of one item in order
// and frees the input side as soon as the last of them is taken.
// ----------------------------------------------------------------------------
module stl_outbuf
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  tok_t       res0,
    input  tok_t       res1,
    input  logic [1:0] res_cnt,
    output logic       can_load,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_res
);

    res_t       ent0_reg, ent0_next;
    res_t       ent1_reg, ent1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = ent0_reg;
    assign pop       = out_valid && out_ready;
    // New results may enter once the buffer is empty after this cycle.
    assign can_load  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_comb
    begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            ent0_next = '{res0, res_cnt == 2'd1};
            ent1_next = '{res1, 1'b1};
            cnt_next  = res_cnt;
        end
        else if (pop)
        begin
            ent0_next = ent1_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

### hw/rtl/source_text_lexer.sv
// ----------------------------------------------------------------------------
// Source text lexer
// Streaming tokenizer: one source byte in per item, token bytes out.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one source byte per item in s_tdata; s_tlast set
// marks end of input, which flushes any pending token and returns the lexer
// to idle (the byte is then ignored). The master channel gives one token
// byte per item, with kind, first and last marks in m_tuser and m_tlast set
// on the last result caused by an input item. Identifier and number bytes,
// and a byte that may open a two-character operator, are held back one item
// so the end of a token can be marked. An input item causes zero, one or two
// results, registered in the two-entry result buffer on acceptance. An item
// with at most one result can be followed by another in the next cycle while
// the receiver is ready; one with two results holds off the next item until
// its first result is taken. When the receiver stalls, the buffered results
// hold and s_tready drops once the buffer cannot take another item's results.
// Reset clears the lexer mode, the held byte and the result buffer.
// ----------------------------------------------------------------------------
module source_text_lexer
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] tok_byte
    output logic [4:0] m_tuser,   // [2:0] tok_kind, [3] tok_first, [4] tok_last
    output logic       m_tlast    // run_end
);

    logic       take;
    logic       can_load;
    tok_t       res0;
    tok_t       res1;
    logic [1:0] res_cnt;
    res_t       out_res;

    assign s_tready = can_load;
    assign take     = s_tvalid && can_load;

    stl_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (s_tdata),
        .is_end  (s_tlast),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    stl_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res0      (res0),
        .res1      (res1),
        .res_cnt   (res_cnt),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.tok.ch;
    assign m_tuser = {out_res.tok.last, out_res.tok.first, out_res.tok.kind};
    assign m_tlast = out_res.run_end;

endmodule
